// ===== sv/kuf_pkg.sv =====
// shared types and constants for the kruskal union-find edge acceptor
package kuf_pkg;

   localparam int NODES       = 1024;
   localparam int COST_BITS   = 32;
   localparam int VTX_W       = $clog2(NODES);
   localparam int RANK_W      = 4;
   localparam int TOTAL_W     = 48;
   localparam int VERTEX_BITS = 10;
   localparam int COST_PORT_W = 32;
   localparam int REQ_DATA_W  = 56;
   localparam int RSP_DATA_W  = 56;

   localparam logic [RANK_W-1:0]  RANK_MAX  = {RANK_W{1'b1}};
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   // one forest entry: parent pointer and rank
   typedef struct packed {
      logic [RANK_W-1:0] rank;
      logic [VTX_W-1:0]  parent;
   } node_type;

   typedef struct packed {
      logic             en;
      logic [VTX_W-1:0] addr;
      node_type         data;
   } node_wr_type;

   // end of one edge: result handed to the total and the response register
   typedef struct packed {
      logic                 fire;
      logic                 accepted;
      logic                 last;
      logic [COST_BITS-1:0] cost;
   } link_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_FIND,
      S_COMP,
      S_LINK,
      S_RANK
   } walk_state_type;

endpackage

// ===== sv/kuf_forest_ram.sv =====
// forest memory: one write port, one registered read port with write forwarding
module kuf_forest_ram (
   input  logic                     clock,
   input  kuf_pkg::node_wr_type     wr,
   input  logic [kuf_pkg::VTX_W-1:0] rd_addr,
   output kuf_pkg::node_type        rd_data
);
   import kuf_pkg::*;

   node_type mem [NODES];
   node_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en && (wr.addr == rd_addr)) begin
         rd_data_ff <= wr.data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/kuf_walker.sv =====
// sequencer: clearing pass, root walks with path compression, union by rank
module kuf_walker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [kuf_pkg::VERTEX_BITS-1:0]   vertex_a,
   input  logic [kuf_pkg::VERTEX_BITS-1:0]   vertex_b,
   input  logic [kuf_pkg::COST_PORT_W-1:0]   edge_cost,
   input  logic                              last_edge,
   input  logic                              out_free,
   output kuf_pkg::node_wr_type              wr,
   output logic [kuf_pkg::VTX_W-1:0]         rd_addr,
   input  kuf_pkg::node_type                 rd_data,
   output kuf_pkg::link_type                 link
);
   import kuf_pkg::*;

   walk_state_type       state_ff, state_in;
   logic                 side_ff, side_in;
   logic [VTX_W-1:0]     cur_ff, cur_in;
   logic [VTX_W-1:0]     va_ff, va_in;
   logic [VTX_W-1:0]     vb_ff, vb_in;
   logic [VTX_W-1:0]     ra_ff, ra_in;
   logic [VTX_W-1:0]     rb_ff, rb_in;
   logic [RANK_W-1:0]    rank_a_ff, rank_a_in;
   logic [RANK_W-1:0]    rank_b_ff, rank_b_in;
   logic [COST_BITS-1:0] cost_ff, cost_in;
   logic                 last_ff, last_in;
   logic                 in_range_ff, in_range_in;
   logic [VTX_W-1:0]     clr_cnt_ff, clr_cnt_in;

   logic                 accept;
   logic                 in_range;
   logic                 joined;
   logic                 a_below;
   logic [VTX_W-1:0]     walk_root;
   logic [VTX_W-1:0]     walk_start;

   assign in_ready = (state_ff == S_IDLE);
   assign accept   = in_valid && in_ready;
   assign in_range = (32'(vertex_a) < NODES) && (32'(vertex_b) < NODES);
   assign joined   = in_range_ff && (ra_ff != rb_ff);
   assign a_below  = (rank_a_ff < rank_b_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      side_ff     <= side_in;
      cur_ff      <= cur_in;
      va_ff       <= va_in;
      vb_ff       <= vb_in;
      ra_ff       <= ra_in;
      rb_ff       <= rb_in;
      rank_a_ff   <= rank_a_in;
      rank_b_ff   <= rank_b_in;
      cost_ff     <= cost_in;
      last_ff     <= last_in;
      in_range_ff <= in_range_in;
   end

   always_comb begin
      state_in    = state_ff;
      side_in     = side_ff;
      cur_in      = cur_ff;
      va_in       = va_ff;
      vb_in       = vb_ff;
      ra_in       = ra_ff;
      rb_in       = rb_ff;
      rank_a_in   = rank_a_ff;
      rank_b_in   = rank_b_ff;
      cost_in     = cost_ff;
      last_in     = last_ff;
      in_range_in = in_range_ff;
      clr_cnt_in  = clr_cnt_ff;
      rd_addr     = cur_ff;
      wr          = '0;
      link        = '0;
      walk_root   = side_ff ? rb_ff : ra_ff;
      walk_start  = side_ff ? vb_ff : va_ff;

      unique case (state_ff)
         S_CLEAR: begin
            wr.en          = 1'b1;
            wr.addr        = clr_cnt_ff;
            wr.data.parent = clr_cnt_ff;
            wr.data.rank   = '0;
            if (clr_cnt_ff == VTX_W'(NODES - 1)) begin
               clr_cnt_in = '0;
               state_in   = S_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + VTX_W'(1);
            end
         end

         S_IDLE: begin
            if (accept) begin
               va_in       = VTX_W'(vertex_a);
               vb_in       = VTX_W'(vertex_b);
               cost_in     = edge_cost[COST_BITS-1:0];
               last_in     = last_edge;
               in_range_in = in_range;
               side_in     = 1'b0;
               cur_in      = VTX_W'(vertex_a);
               rd_addr     = VTX_W'(vertex_a);
               state_in    = in_range ? S_FIND : S_LINK;
            end
         end

         S_FIND: begin
            if (rd_data.parent == cur_ff) begin
               if (side_ff) begin
                  rb_in     = cur_ff;
                  rank_b_in = rd_data.rank;
               end else begin
                  ra_in     = cur_ff;
                  rank_a_in = rd_data.rank;
               end
               if (walk_start != cur_ff) begin
                  // second pass from the endpoint to point every node at the root
                  cur_in   = walk_start;
                  rd_addr  = walk_start;
                  state_in = S_COMP;
               end else if (!side_ff) begin
                  side_in  = 1'b1;
                  cur_in   = vb_ff;
                  rd_addr  = vb_ff;
                  state_in = S_FIND;
               end else begin
                  state_in = S_LINK;
               end
            end else begin
               cur_in  = rd_data.parent;
               rd_addr = rd_data.parent;
            end
         end

         S_COMP: begin
            wr.en          = 1'b1;
            wr.addr        = cur_ff;
            wr.data.parent = walk_root;
            wr.data.rank   = rd_data.rank;
            if (rd_data.parent != walk_root) begin
               cur_in  = rd_data.parent;
               rd_addr = rd_data.parent;
            end else if (!side_ff) begin
               side_in  = 1'b1;
               cur_in   = vb_ff;
               rd_addr  = vb_ff;
               state_in = S_FIND;
            end else begin
               state_in = S_LINK;
            end
         end

         S_LINK: begin
            if (out_free) begin
               link.fire     = 1'b1;
               link.accepted = joined;
               link.last     = last_ff;
               link.cost     = cost_ff;
               state_in      = last_ff ? S_CLEAR : S_IDLE;
               if (joined) begin
                  wr.en = 1'b1;
                  if (a_below) begin
                     wr.addr        = ra_ff;
                     wr.data.parent = rb_ff;
                     wr.data.rank   = rank_a_ff;
                  end else begin
                     wr.addr        = rb_ff;
                     wr.data.parent = ra_ff;
                     wr.data.rank   = rank_b_ff;
                     if ((rank_a_ff == rank_b_ff) && (rank_a_ff != RANK_MAX)) begin
                        state_in = S_RANK;
                     end
                  end
               end
            end
         end

         S_RANK: begin
            wr.en          = 1'b1;
            wr.addr        = ra_ff;
            wr.data.parent = ra_ff;
            wr.data.rank   = rank_a_ff + RANK_W'(1);
            state_in       = last_ff ? S_CLEAR : S_IDLE;
         end

         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

endmodule

// ===== sv/kuf_total_acc.sv =====
// running tree cost with saturation and sticky flag
module kuf_total_acc (
   input  logic                          clock,
   input  logic                          reset,
   input  kuf_pkg::link_type             link,
   output logic [kuf_pkg::TOTAL_W-1:0]   total_next,
   output logic                          sat_next
);
   import kuf_pkg::*;

   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               sat_ff, sat_in;
   logic [TOTAL_W:0]   sum;
   logic               hits_max;

   assign sum      = {1'b0, total_ff} + (TOTAL_W + 1)'(link.cost);
   assign hits_max = (sum >= {1'b0, TOTAL_MAX});

   always_comb begin
      total_next = total_ff;
      sat_next   = sat_ff;
      if (link.accepted) begin
         total_next = hits_max ? TOTAL_MAX : sum[TOTAL_W-1:0];
         sat_next   = sat_ff || hits_max;
      end
      total_in = total_ff;
      sat_in   = sat_ff;
      if (link.fire) begin
         // a last edge reports its total, then the sum starts over
         total_in = link.last ? '0 : total_next;
         sat_in   = link.last ? 1'b0 : sat_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         sat_ff   <= 1'b0;
      end else begin
         total_ff <= total_in;
         sat_ff   <= sat_in;
      end
   end

endmodule

// ===== sv/kruskal_union_find_edge_acceptor.sv =====
// top level: edge stream in, accept/total stream out, union-find forest in one ram
//
// Usage:
//   req channel carries one graph edge per beat, in ascending cost order.
//   req_tdata = {pad, edge_cost, vertex_b, vertex_a}; req_tlast marks the
//   last edge of a graph. rsp channel returns one beat per edge:
//   rsp_tdata = {pad, total_saturated, tree_total, accepted}.
//   Per edge: an accept step, then for each endpoint a find step per level
//   of its root walk plus a compress step per node it recompresses, then a
//   link step and a rank step when a root rank grows. Walks are at most
//   about log2(1024) levels deep. The walker is a single read/modify/write
//   loop on the forest memory, so one edge is in flight at a time.
//   After reset, and after each edge flagged by tlast, a clearing pass
//   rewrites all 1024 forest entries; req_tready stays low meanwhile.
//   The result sits in an output register: a stalled receiver does not
//   block the next edge from being accepted and walked, only its link cycle
//   waits until the register frees.
module kruskal_union_find_edge_acceptor (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [kuf_pkg::REQ_DATA_W-1:0]      req_tdata,  // vertex_a, vertex_b, edge_cost
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [kuf_pkg::RSP_DATA_W-1:0]      rsp_tdata   // accepted, tree_total, total_saturated
);
   import kuf_pkg::*;

   localparam int A_LO = 0;
   localparam int B_LO = VERTEX_BITS;
   localparam int C_LO = 2 * VERTEX_BITS;

   node_wr_type        wr;
   logic [VTX_W-1:0]   rd_addr;
   node_type           rd_data;
   link_type           link;
   logic               out_free;
   logic [TOTAL_W-1:0] total_next;
   logic               sat_next;

   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   assign out_free = !rsp_tvalid_ff || rsp_tready;

   kuf_forest_ram u_ram (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   kuf_walker u_walker (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .vertex_a  (req_tdata[A_LO +: VERTEX_BITS]),
      .vertex_b  (req_tdata[B_LO +: VERTEX_BITS]),
      .edge_cost (req_tdata[C_LO +: COST_PORT_W]),
      .last_edge (req_tlast),
      .out_free  (out_free),
      .wr        (wr),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .link      (link)
   );

   kuf_total_acc u_total (
      .clock      (clock),
      .reset      (reset),
      .link       (link),
      .total_next (total_next),
      .sat_next   (sat_next)
   );

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      if (link.fire) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = RSP_DATA_W'({sat_next, total_next, link.accepted});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule
